[hdl/frg_pkg.sv]
package frg_pkg;

    localparam int unsigned CFG_W     = 32;
    localparam int unsigned LOAD_IN_W = 64;
    localparam int unsigned FEE_W     = 36;
    localparam int unsigned FLOOR_W   = 32;
    localparam int unsigned PROD_W    = 64;
    localparam int unsigned DIV_CNT_W = 6;

    localparam logic [CFG_W-1:0] TARGET_LOAD_RESET = 32'd20000;
    localparam logic [CFG_W-1:0] TARGET_FEE_RESET  = 32'd10000;

    // Multiplying by this constant and shifting right by 34 divides any 32-bit value by 5.
    localparam logic [CFG_W-1:0] RECIP_FIVE = 32'hCCCC_CCCD;
    localparam int unsigned      RECIP_SHIFT = 34;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'd63;

    typedef enum logic {
        REG_TARGET_LOAD = 1'b0,
        REG_TARGET_FEE  = 1'b1
    } frg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_RECIP,
        S_DIV,
        S_SEL,
        S_UPDATE
    } frg_state_t;

endpackage

[hdl/fee_rate_governor_step.sv]
// Channel   | Handshake                | Payload
// ----------+--------------------------+-------------------------------------------
// in        | in_valid / in_ready      | observed_load
// out       | out_valid / out_ready    | fee, previous_fee, fee_floor, fee_ceiling
// cfg       | cfg_we                   | cfg_index, cfg_data
//
// When target_load is nonzero, a request passes the multiply and reciprocal states, then
// the 64-step restoring divider that produces target_fee*load/target_load, then select.
// With target_load at zero the divider is skipped and multiply goes straight to update.
// The block takes one request at a time; in_ready is high only while it is idle.
// A finished result waits in the output register, and the next request may start then.
// Reset clears the kept fee to zero and loads the register reset values.
module fee_rate_governor_step
    import frg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [LOAD_IN_W-1:0] observed_load,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [FEE_W-1:0]     fee,
    output logic [FEE_W-1:0]     previous_fee,
    output logic [FLOOR_W-1:0]   fee_floor,
    output logic [FEE_W-1:0]     fee_ceiling
);

    frg_state_t             state_reg, state_next;
    logic [CFG_W-1:0]       target_load_reg, target_fee_reg;
    logic [FEE_W-1:0]       fee_now_reg;
    logic [CFG_W-1:0]       load_reg;
    logic [PROD_W-1:0]      divd_reg;
    logic [CFG_W-1:0]       rem_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [CFG_W-1:0]       step_reg;
    logic [FEE_W-1:0]       desired_reg;
    logic                   out_valid_reg;
    logic [FEE_W-1:0]       fee_reg, previous_fee_reg, fee_ceiling_reg;
    logic [FLOOR_W-1:0]     fee_floor_reg;

    logic                   accept_in, out_free, do_update;
    logic                   mul_recip;
    logic [CFG_W-1:0]       mul_a, mul_b;
    logic [PROD_W-1:0]      mul_out;
    logic [CFG_W:0]         div_shift, div_diff;
    logic                   div_ge;
    logic                   adjust_off;
    logic [FEE_W-1:0]       lo_w, hi_w;
    logic [PROD_W-1:0]      sel_max;
    logic [FEE_W-1:0]       sel_desired;
    logic [FEE_W:0]         up_w, raw_w, clamp_lo_w, clamp_w;
    logic [FEE_W-1:0]       nf_w;

    assign accept_in  = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign adjust_off = (target_load_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = adjust_off ? S_UPDATE : S_RECIP;
            end
            S_RECIP:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        mul_recip = 1'b0;
        do_update = 1'b0;
        unique case (state_reg)
            S_IDLE:   in_ready  = 1'b1;
            S_RECIP:  mul_recip = 1'b1;
            S_UPDATE: do_update = out_free;
            default:  in_ready  = 1'b0;
        endcase
    end

    // The one multiplier forms the dividend first and the step by target_fee/20 after it.
    assign mul_a   = mul_recip ? {2'b00, target_fee_reg[CFG_W-1:2]} : target_fee_reg;
    assign mul_b   = mul_recip ? RECIP_FIVE : load_reg;
    assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign div_shift = {rem_reg, divd_reg[PROD_W-1]};
    assign div_ge    = (div_shift >= {1'b0, target_load_reg});
    assign div_diff  = div_shift - {1'b0, target_load_reg};

    assign lo_w = (target_fee_reg[CFG_W-1:1] == '0) ? FEE_W'(1)
                                                    : FEE_W'(target_fee_reg[CFG_W-1:1]);
    assign hi_w = {1'b0, target_fee_reg, 3'b000} + {3'b000, target_fee_reg, 1'b0};

    assign sel_max     = (divd_reg < PROD_W'(lo_w)) ? PROD_W'(lo_w) : divd_reg;
    assign sel_desired = (sel_max > PROD_W'(hi_w)) ? hi_w : sel_max[FEE_W-1:0];

    assign up_w = {1'b0, fee_now_reg} + (FEE_W+1)'(step_reg);

    always_comb
    begin
        priority if (desired_reg > fee_now_reg)
        begin
            raw_w = up_w;
        end
        else if (fee_now_reg >= FEE_W'(step_reg))
        begin
            raw_w = {1'b0, fee_now_reg} - (FEE_W+1)'(step_reg);
        end
        else
        begin
            raw_w = {1'b0, lo_w};
        end
        clamp_lo_w = (raw_w < {1'b0, lo_w}) ? {1'b0, lo_w} : raw_w;
        clamp_w    = (clamp_lo_w > {1'b0, hi_w}) ? {1'b0, hi_w} : clamp_lo_w;
        priority if (adjust_off)
        begin
            nf_w = FEE_W'(target_fee_reg);
        end
        else if (desired_reg == fee_now_reg)
        begin
            nf_w = desired_reg;
        end
        else
        begin
            nf_w = clamp_w[FEE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            target_load_reg <= TARGET_LOAD_RESET;
            target_fee_reg  <= TARGET_FEE_RESET;
            fee_now_reg     <= '0;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_TARGET_LOAD)
                begin
                    target_load_reg <= cfg_data;
                end
                else
                begin
                    target_fee_reg <= cfg_data;
                end
            end
            if (state_reg == S_RECIP)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (do_update)
            begin
                fee_now_reg   <= nf_w;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            load_reg <= (observed_load[LOAD_IN_W-1:CFG_W] != '0) ? '1
                                                                 : observed_load[CFG_W-1:0];
        end
        unique case (state_reg)
            S_MUL:
            begin
                divd_reg <= mul_out;
                rem_reg  <= '0;
            end
            S_RECIP:
            begin
                step_reg <= (mul_out[PROD_W-1:RECIP_SHIFT] == '0)
                          ? CFG_W'(1) : CFG_W'(mul_out[PROD_W-1:RECIP_SHIFT]);
            end
            S_DIV:
            begin
                rem_reg  <= div_ge ? div_diff[CFG_W-1:0] : div_shift[CFG_W-1:0];
                divd_reg <= {divd_reg[PROD_W-2:0], div_ge};
            end
            S_SEL:
            begin
                desired_reg <= sel_desired;
            end
            default:
            begin
            end
        endcase
        if (do_update)
        begin
            fee_reg          <= nf_w;
            previous_fee_reg <= (fee_now_reg == '0) ? nf_w : fee_now_reg;
            fee_floor_reg    <= adjust_off ? target_fee_reg : lo_w[FLOOR_W-1:0];
            fee_ceiling_reg  <= adjust_off ? FEE_W'(target_fee_reg) : hi_w;
        end
    end

    assign out_valid    = out_valid_reg;
    assign fee          = fee_reg;
    assign previous_fee = previous_fee_reg;
    assign fee_floor    = fee_floor_reg;
    assign fee_ceiling  = fee_ceiling_reg;

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < target_load_reg))
        else $error("divider remainder not below divisor");

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == DIV_LAST) |=> (state_reg == S_SEL))
        else $error("divider did not finish after its last step");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> (state_reg == S_MUL))
        else $error("accepted request did not start the multiply");

    a_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (fee_reg <= fee_ceiling_reg))
        else $error("fee above ceiling");

endmodule
